>>> sv/vsd_pkg.sv
// Shared types and constants of the voice segment detector.
package vsd_pkg;

    localparam int unsigned POS_OUT_BITS = 24;
    localparam int unsigned SEG_OUT_BITS = 7;
    localparam logic [7:0]  HEADER_RESET = 8'd100;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0]  level_threshold;
        logic [15:0] silence_hangover;
        logic [15:0] min_length;
        logic [15:0] max_length;
        logic [7:0]  header_skip;
    } t_cfg;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic [SEG_OUT_BITS-1:0] seg_number;
        logic [POS_OUT_BITS-1:0] start_pos;
        logic [POS_OUT_BITS-1:0] end_pos;
        logic [SEG_OUT_BITS-1:0] seg_total;
    } t_res;

endpackage

>>> sv/vsd_if.sv
// Sample and result channel interfaces of the voice segment detector.
interface vsd_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] sample;
    logic              is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink (input valid, input sample, input is_last, output ready);
endinterface

interface vsd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  seg_number;
    logic [23:0] start_pos;
    logic [23:0] end_pos;
    logic [6:0]  seg_total;

    modport source (
        output valid, output kind, output seg_number, output start_pos,
        output end_pos, output seg_total, input ready
    );
    modport sink (
        input valid, input kind, input seg_number, input start_pos,
        input end_pos, input seg_total, output ready
    );
endinterface

>>> sv/vsd_cfg.sv
// APB configuration registers of the voice segment detector.
module vsd_cfg
    import vsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    localparam logic [2:0] REG_LEVEL    = 3'd0;
    localparam logic [2:0] REG_HANGOVER = 3'd1;
    localparam logic [2:0] REG_MIN_LEN  = 3'd2;
    localparam logic [2:0] REG_MAX_LEN  = 3'd3;
    localparam logic [2:0] REG_HEADER   = 3'd4;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold  <= '0;
            r_cfg.silence_hangover <= '0;
            r_cfg.min_length       <= '0;
            r_cfg.max_length       <= '0;
            r_cfg.header_skip      <= HEADER_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LEVEL:    r_cfg.level_threshold  <= pwdata[7:0];
                REG_HANGOVER: r_cfg.silence_hangover <= pwdata[15:0];
                REG_MIN_LEN:  r_cfg.min_length       <= pwdata[15:0];
                REG_MAX_LEN:  r_cfg.max_length       <= pwdata[15:0];
                REG_HEADER:   r_cfg.header_skip      <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEVEL:    prdata = {24'd0, r_cfg.level_threshold};
            REG_HANGOVER: prdata = {16'd0, r_cfg.silence_hangover};
            REG_MIN_LEN:  prdata = {16'd0, r_cfg.min_length};
            REG_MAX_LEN:  prdata = {16'd0, r_cfg.max_length};
            REG_HEADER:   prdata = {24'd0, r_cfg.header_skip};
            default:      prdata = '0;
        endcase
    end

endmodule

>>> sv/vsd_seg.sv
// Input register, stream state and segment decision logic.
module vsd_seg
    import vsd_pkg::*;
#(
    parameter int POS_BITS     = 24,
    parameter int MAX_SEGMENTS = 127
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    vsd_in_if.sink i_in,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int FCW = $clog2(MAX_SEGMENTS + 1);

    logic                r_s1_valid;
    logic signed [7:0]   r_sample;
    logic                r_last;

    logic [POS_BITS-1:0] r_pos;
    logic                r_in_seg;
    logic [POS_BITS-1:0] r_open_start;
    logic [15:0]         r_voiced;
    logic [15:0]         r_quiet;
    logic [FCW-1:0]      r_found;

    logic [POS_BITS-1:0] n_pos;
    logic                n_in_seg;
    logic [POS_BITS-1:0] n_open_start;
    logic [15:0]         n_voiced;
    logic [15:0]         n_quiet;
    logic [FCW-1:0]      n_found;

    logic [7:0]          mag;
    logic                is_voiced;
    logic [POS_BITS-1:0] pos_next;
    logic                active;
    logic                t_in;
    logic [15:0]         t_v;
    logic [15:0]         t_q;
    logic                quiet_close;
    logic [15:0]         seg_len;
    logic                produce;
    logic                adv;
    t_res                res;
    logic [31:0]         start_wide;
    logic [31:0]         end_wide;

    assign mag       = r_sample[7] ? 8'(~r_sample + 8'sd1) : r_sample;
    assign is_voiced = mag > i_cfg.level_threshold;
    assign pos_next  = (&r_pos) ? r_pos : r_pos + POS_BITS'(1);
    assign active    = (r_pos >= POS_BITS'(i_cfg.header_skip))
                       && (r_found < FCW'(MAX_SEGMENTS));
    assign start_wide = 32'(r_in_seg ? r_open_start : r_pos);
    assign end_wide   = 32'(pos_next);

    always_comb begin
        n_pos        = r_pos;
        n_in_seg     = r_in_seg;
        n_open_start = r_open_start;
        n_voiced     = r_voiced;
        n_quiet      = r_quiet;
        n_found      = r_found;
        t_in         = r_in_seg;
        t_v          = r_voiced;
        t_q          = r_quiet;
        quiet_close  = 1'b0;
        seg_len      = '0;
        produce      = 1'b0;
        res          = '0;

        if (r_last) begin
            produce       = 1'b1;
            res.kind      = KIND_SUMMARY;
            res.seg_total = SEG_OUT_BITS'(r_found);
            n_pos         = '0;
            n_in_seg      = 1'b0;
            n_open_start  = '0;
            n_voiced      = '0;
            n_quiet       = '0;
            n_found       = '0;
        end else begin
            n_pos = pos_next;
            if (i_cfg.max_length == 16'd0) begin
                n_in_seg = 1'b0;
                n_voiced = '0;
                n_quiet  = '0;
            end else if (active) begin
                if (!r_in_seg) begin
                    if (is_voiced) begin
                        t_in         = 1'b1;
                        n_open_start = r_pos;
                        t_v          = 16'd1;
                        t_q          = 16'd0;
                    end
                end else begin
                    t_v = r_voiced + 16'd1;
                    t_q = is_voiced ? 16'd0 : r_quiet + 16'd1;
                end
                quiet_close = t_q > i_cfg.silence_hangover;
                seg_len     = quiet_close ? t_v - t_q : t_v;
                n_in_seg    = t_in;
                n_voiced    = t_v;
                n_quiet     = t_q;
                if (t_in && (t_v >= i_cfg.max_length || quiet_close)) begin
                    n_in_seg = 1'b0;
                    n_voiced = '0;
                    n_quiet  = '0;
                    if (seg_len >= i_cfg.min_length) begin
                        produce        = 1'b1;
                        res.kind       = KIND_SEGMENT;
                        res.seg_number = SEG_OUT_BITS'(r_found);
                        res.start_pos  = start_wide[POS_OUT_BITS-1:0];
                        res.end_pos    = end_wide[POS_OUT_BITS-1:0];
                        n_found        = r_found + FCW'(1);
                    end
                end
            end
        end
        adv       = r_s1_valid && (!produce || i_res_ready);
        res.valid = adv && produce;
    end

    assign i_in.ready = !r_s1_valid || adv;
    assign o_res      = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_pos        <= '0;
            r_in_seg     <= 1'b0;
            r_open_start <= '0;
            r_voiced     <= '0;
            r_quiet      <= '0;
            r_found      <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (adv) begin
                r_pos        <= n_pos;
                r_in_seg     <= n_in_seg;
                r_open_start <= n_open_start;
                r_voiced     <= n_voiced;
                r_quiet      <= n_quiet;
                r_found      <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_sample <= i_in.sample;
            r_last   <= i_in.is_last;
        end
    end

endmodule

>>> sv/voice_segment_detector.sv
// Top level of the voice segment detector: configuration, segment logic, result register.
//
// The detector takes one audio sample per clock and keeps that rate as long as the
// result side takes its beats. A sample passes an input register, where the stream
// counters and the open segment are updated, and its result, if any, is registered
// in the output register once the output side can take it. A sample that yields no
// result never waits on the output side.
// The user must write configuration over the APB port only while no samples are in
// flight; the block itself does not enforce this.
module voice_segment_detector
    import vsd_pkg::*;
#(
    parameter int POS_BITS     = 24,
    parameter int MAX_SEGMENTS = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    vsd_in_if.sink      i_in,
    vsd_out_if.source   o_out
);

    t_cfg cfg;
    t_res res;
    logic res_ready;
    t_res r_out;

    vsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vsd_seg #(
        .POS_BITS     (POS_BITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_seg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out.valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out.valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.seg_number = r_out.seg_number;
    assign o_out.start_pos  = r_out.start_pos;
    assign o_out.end_pos    = r_out.end_pos;
    assign o_out.seg_total  = r_out.seg_total;

endmodule
